/* src/dud_pkg.sv */
package dud_pkg;

   // Field widths of the words on the ports.
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int DAYS_W   = 22;

   // The normalized deadline can land one year past the widest year field.
   localparam int WALK_YEAR_W = YEAR_W + 1;
   // One spare bit over the result so that saturation is a single bit test.
   localparam int COUNT_W     = DAYS_W + 1;
   // A single step adds at most a whole leap year.
   localparam int STEP_W      = 9;

   // Division by 100 through a reciprocal: q = (y * 5243) >> 19 is exact
   // for every 14-bit year.
   localparam int             RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int             RECIP_SHIFT = 19;
   localparam int             PROD_W      = YEAR_W + RECIP_W;
   localparam int             QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam int             MOD100_W    = 7;
   localparam logic [MOD100_W-1:0] MOD100_LAST = 7'd99;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = YEAR_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEADLINE_YEAR  = 2'd0,
      CSR_DEADLINE_MONTH = 2'd1,
      CSR_DEADLINE_DAY   = 2'd2
   } csr_index_type;

   localparam logic [YEAR_W-1:0]  DEADLINE_YEAR_RST  = 14'd2022;
   localparam logic [MONTH_W-1:0] DEADLINE_MONTH_RST = 4'd12;
   localparam logic [DAY_W-1:0]   DEADLINE_DAY_RST   = 5'd5;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

   localparam logic [STEP_W-1:0]  DAYS_PER_YEAR = 9'd365;

   typedef struct packed {
      logic [YEAR_W-1:0]  start_year;
      logic [MONTH_W-1:0] start_month;
      logic [DAY_W-1:0]   start_day;
   } req_word_type;

   typedef struct packed {
      logic [DAYS_W-1:0] days_left;
      logic              date_invalid;
   } rsp_word_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic load_start;
      logic mul_en;
      logic mul_sel_start;
      logic norm_deadline;
      logic init_walk;
      logic walk_step;
      logic rsp_load;
   } dud_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic run;
      logic walk_last;
   } dud_stat_type;

   // Gregorian leap rule from the year's low bits, its remainder by 100
   // and its century count modulo 4.
   function automatic logic is_leap(input logic [1:0]          year_low,
                                    input logic [MOD100_W-1:0] mod100,
                                    input logic [1:0]          cent);
      logic leap;
      leap = ((year_low == 2'd0) && (mod100 != '0)) ||
             ((mod100 == '0) && (cent == 2'd0));
      return leap;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic               leap,
                                                  input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      case (month)
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

/* src/dud_ctrl.sv */
module dud_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_free,
   input  dud_pkg::dud_stat_type stat,
   output dud_pkg::dud_cmd_type  cmd
);
   import dud_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DL_MUL   = 7'b0000010,
      ST_DL_NORM  = 7'b0000100,
      ST_ST_MUL   = 7'b0001000,
      ST_ST_CHECK = 7'b0010000,
      ST_WALK     = 7'b0100000,
      ST_DONE     = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_start = req_valid;
            if (req_valid) begin
               state_in = ST_DL_MUL;
            end
         end
         ST_DL_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_DL_NORM;
         end
         ST_DL_NORM: begin
            cmd.norm_deadline = 1'b1;
            state_in          = ST_ST_MUL;
         end
         ST_ST_MUL: begin
            cmd.mul_en        = 1'b1;
            cmd.mul_sel_start = 1'b1;
            state_in          = ST_ST_CHECK;
         end
         ST_ST_CHECK: begin
            cmd.init_walk = 1'b1;
            state_in      = stat.run ? ST_WALK : ST_DONE;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.rsp_load = rsp_free;
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/dud_datapath.sv */
module dud_datapath (
   input  logic                          clock,
   input  dud_pkg::dud_cmd_type          cmd,
   input  dud_pkg::req_word_type         req_word,
   input  logic [dud_pkg::YEAR_W-1:0]    deadline_year,
   input  logic [dud_pkg::MONTH_W-1:0]   deadline_month,
   input  logic [dud_pkg::DAY_W-1:0]     deadline_day,
   output dud_pkg::dud_stat_type         stat,
   output logic [dud_pkg::DAYS_W-1:0]    days_left,
   output logic                          date_invalid
);
   import dud_pkg::*;

   logic [YEAR_W-1:0]      start_year_ff;
   logic [MONTH_W-1:0]     start_month_ff;
   logic [DAY_W-1:0]       start_day_ff;

   logic [PROD_W-1:0]      prod_ff;
   logic [YEAR_W-1:0]      mul_year_ff;

   logic [WALK_YEAR_W-1:0] eff_year_ff;
   logic [MONTH_W-1:0]     eff_month_ff;
   logic [DAY_W-1:0]       eff_day_ff;

   logic [WALK_YEAR_W-1:0] walk_year_ff;
   logic [MONTH_W-1:0]     walk_month_ff;
   logic [DAY_W-1:0]       walk_day_ff;
   logic [MOD100_W-1:0]    mod100_ff;
   logic [1:0]             cent_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   bad_ff;

   // Year analysis shared by the deadline and the start date.
   logic [YEAR_W-1:0]      mul_year;
   logic [QUOT_W-1:0]      unit_quot;
   logic [YEAR_W-1:0]      unit_quot_x100;
   logic [MOD100_W-1:0]    unit_mod100;
   logic                   unit_leap;

   logic [WALK_YEAR_W-1:0] norm_year;
   logic [MONTH_W-1:0]     norm_month;
   logic [DAY_W-1:0]       norm_day;
   logic [DAY_W-1:0]       dl_len;

   logic [DAY_W-1:0]       st_len;
   logic                   bad;
   logic                   start_early;

   logic                   cur_leap;
   logic [DAY_W-1:0]       cur_len;
   logic                   same_month;
   logic                   year_jump;
   logic                   year_adv;
   logic [STEP_W-1:0]      step;
   logic [WALK_YEAR_W-1:0] walk_year_in;
   logic [MONTH_W-1:0]     walk_month_in;
   logic [DAY_W-1:0]       walk_day_in;
   logic [MOD100_W-1:0]    mod100_in;
   logic [1:0]             cent_in;

   assign mul_year       = cmd.mul_sel_start ? start_year_ff : deadline_year;
   assign unit_quot      = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign unit_quot_x100 = (YEAR_W'(unit_quot) << 6) + (YEAR_W'(unit_quot) << 5) +
                           (YEAR_W'(unit_quot) << 2);
   assign unit_mod100    = MOD100_W'(mul_year_ff - unit_quot_x100);
   assign unit_leap      = is_leap(mul_year_ff[1:0], unit_mod100, unit_quot[1:0]);

   // An impossible deadline moves forward to the first real date after it.
   always_comb begin
      dl_len     = month_len(unit_leap, deadline_month);
      norm_year  = {1'b0, mul_year_ff};
      norm_month = deadline_month;
      norm_day   = deadline_day;
      if (deadline_month == '0) begin
         norm_month = MONTH_JAN;
         norm_day   = DAY_FIRST;
      end else if (deadline_month > MONTH_DEC) begin
         norm_year  = norm_year + 1'b1;
         norm_month = MONTH_JAN;
         norm_day   = DAY_FIRST;
      end else if (deadline_day == '0) begin
         norm_day = DAY_FIRST;
      end else if (deadline_day > dl_len) begin
         norm_day = DAY_FIRST;
         if (deadline_month == MONTH_DEC) begin
            norm_year  = norm_year + 1'b1;
            norm_month = MONTH_JAN;
         end else begin
            norm_month = deadline_month + 1'b1;
         end
      end
   end

   assign st_len      = month_len(unit_leap, start_month_ff);
   assign bad         = (start_month_ff == '0) || (start_month_ff > MONTH_DEC) ||
                        (start_day_ff == '0) || (start_day_ff > st_len);
   assign start_early = {1'b0, start_year_ff, start_month_ff, start_day_ff} <
                        {eff_year_ff, eff_month_ff, eff_day_ff};
   assign stat.run    = !bad && start_early;

   // One walk step: finish inside the deadline month, jump a whole year
   // from January 1, or else run to the first of the next month.
   always_comb begin
      cur_leap   = is_leap(walk_year_ff[1:0], mod100_ff, cent_ff);
      cur_len    = month_len(cur_leap, walk_month_ff);
      same_month = (walk_year_ff == eff_year_ff) && (walk_month_ff == eff_month_ff);
      year_jump  = (walk_month_ff == MONTH_JAN) && (walk_day_ff == DAY_FIRST) &&
                   (walk_year_ff < eff_year_ff);
      year_adv   = 1'b0;
      walk_month_in = walk_month_ff;
      walk_day_in   = DAY_FIRST;
      if (same_month) begin
         step        = STEP_W'(eff_day_ff - walk_day_ff);
         walk_day_in = eff_day_ff;
      end else if (year_jump) begin
         step     = DAYS_PER_YEAR + STEP_W'(cur_leap);
         year_adv = 1'b1;
      end else begin
         step = STEP_W'(cur_len) - STEP_W'(walk_day_ff) + 1'b1;
         if (walk_month_ff == MONTH_DEC) begin
            walk_month_in = MONTH_JAN;
            year_adv      = 1'b1;
         end else begin
            walk_month_in = walk_month_ff + 1'b1;
         end
      end
      walk_year_in = walk_year_ff;
      mod100_in    = mod100_ff;
      cent_in      = cent_ff;
      if (year_adv) begin
         walk_year_in = walk_year_ff + 1'b1;
         if (mod100_ff == MOD100_LAST) begin
            mod100_in = '0;
            cent_in   = cent_ff + 1'b1;
         end else begin
            mod100_in = mod100_ff + 1'b1;
         end
      end
   end

   assign stat.walk_last = same_month;

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         start_year_ff  <= req_word.start_year;
         start_month_ff <= req_word.start_month;
         start_day_ff   <= req_word.start_day;
      end
      if (cmd.mul_en) begin
         prod_ff     <= PROD_W'(mul_year) * PROD_W'(RECIP_100);
         mul_year_ff <= mul_year;
      end
      if (cmd.norm_deadline) begin
         eff_year_ff  <= norm_year;
         eff_month_ff <= norm_month;
         eff_day_ff   <= norm_day;
      end
      if (cmd.init_walk) begin
         walk_year_ff  <= {1'b0, start_year_ff};
         walk_month_ff <= start_month_ff;
         walk_day_ff   <= start_day_ff;
         mod100_ff     <= unit_mod100;
         cent_ff       <= unit_quot[1:0];
         count_ff      <= '0;
         bad_ff        <= bad;
      end else if (cmd.walk_step) begin
         walk_year_ff  <= walk_year_in;
         walk_month_ff <= walk_month_in;
         walk_day_ff   <= walk_day_in;
         mod100_ff     <= mod100_in;
         cent_ff       <= cent_in;
         count_ff      <= count_ff + COUNT_W'(step);
      end
   end

   assign days_left    = count_ff[COUNT_W-1] ? '1 : count_ff[DAYS_W-1:0];
   assign date_invalid = bad_ff;

endmodule

/* src/days_until_date_counter_core.sv */
// Counts the days from a start date (year, month, day) up to a deadline date
// held in three configuration registers, in the proleptic Gregorian calendar.
// Each accepted word on the req channel yields exactly one word on the rsp
// channel. A start date on or after the deadline gives 0 days; an impossible
// start date (month outside 1 to 12, day 0, or a day past the end of its
// month) gives 0 days with date_invalid set. An impossible deadline is read
// as the first real date that follows it, and counts beyond 4194303 saturate.
// The block handles one word at a time. After a word is taken, the sequencer
// analyzes the deadline year, normalizes the deadline, analyzes the start
// year and checks the start date, then a walker advances the date in coarse
// steps: one step per month up to the next January 1, one per whole year, one
// per month inside the deadline year, and a final step into the deadline day.
// A word that yields 0 days skips the walker. The walker step is the limit.
// A finished word waits in the rsp output register, so the next req word is
// taken and processed while the previous result is still pending. The
// deadline registers must only be written while the block is idle.
module days_until_date_counter_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  dud_pkg::req_word_type            req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output dud_pkg::rsp_word_type            rsp_data,
   input  logic                             csr_wr_en,
   input  logic [dud_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dud_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import dud_pkg::*;

   // Deadline configuration registers.
   logic [YEAR_W-1:0]  deadline_year_ff;
   logic [MONTH_W-1:0] deadline_month_ff;
   logic [DAY_W-1:0]   deadline_day_ff;

   // Result output register.
   logic               rsp_valid_ff;
   rsp_word_type       rsp_data_ff;
   logic               rsp_free;

   dud_cmd_type        cmd;
   dud_stat_type       stat;
   logic [DAYS_W-1:0]  days_left;
   logic               date_invalid;

   // Writes to an index outside the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_year_ff  <= DEADLINE_YEAR_RST;
         deadline_month_ff <= DEADLINE_MONTH_RST;
         deadline_day_ff   <= DEADLINE_DAY_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_DEADLINE_YEAR:  deadline_year_ff  <= csr_wr_data[YEAR_W-1:0];
            CSR_DEADLINE_MONTH: deadline_month_ff <= csr_wr_data[MONTH_W-1:0];
            CSR_DEADLINE_DAY:   deadline_day_ff   <= csr_wr_data[DAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The sequencer may hand over a result only when the output register is
   // empty or being emptied in the same cycle.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   dud_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_free  (rsp_free),
      .stat      (stat),
      .cmd       (cmd)
   );

   dud_datapath u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .req_word       (req_data),
      .deadline_year  (deadline_year_ff),
      .deadline_month (deadline_month_ff),
      .deadline_day   (deadline_day_ff),
      .stat           (stat),
      .days_left      (days_left),
      .date_invalid   (date_invalid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff.days_left    <= days_left;
         rsp_data_ff.date_invalid <= date_invalid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Once a word is taken the block is busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready stayed high right after a word was taken");

   // A result never overwrites one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> rsp_free)
      else $error("result loaded into an occupied output register");

   // An impossible start date always reports zero days.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.date_invalid) |-> (rsp_data.days_left == '0))
      else $error("invalid date reported with a nonzero day count");

endmodule

/* dv/testbench.sv */
module testbench;
   import dud_pkg::*;

   // The walker takes one step per whole year, so a start date near year 0
   // against a deadline near the top of the year field keeps the block busy
   // longest, and the long receiver hold-off adds to that. The watchdog limit
   // leaves a wide margin over both.
   localparam int unsigned STALL_LIMIT     = 100000;
   localparam int unsigned RSP_HOLD_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES    = 20;
   localparam int unsigned DAYS_CEILING    = 4194303;
   localparam int unsigned YEAR_TOP        = 16383;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_word_type           req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_word_type           rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   // Our own copy of the deadline registers, starting from their reset values.
   int unsigned  dl_year  = 2022;
   int unsigned  dl_month = 12;
   int unsigned  dl_day   = 5;

   // Answers still owed by the block, oldest first.
   rsp_word_type days_due[$];

   int unsigned  errors = 0;
   int unsigned  stall_cycles = 0;

   // Idling controls. Each side draws a fresh wait for every word while its
   // flag is set; clearing the flags gives stretches at full rate.
   bit           req_idle = 1'b1;
   bit           rsp_idle = 1'b1;
   int unsigned  req_gap = 0;
   // When set, the receiver keeps rsp_ready low for a long stretch after its
   // next accepted word, so that the block backs up into the req channel.
   bit           hold_rsp = 1'b0;

   days_until_date_counter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Calendar arithmetic of the predictor.
   // ---------------------------------------------------------------------

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   // Month must be 1 to 12 here.
   function automatic int unsigned days_in_month(input int unsigned y,
                                                 input int unsigned m);
      int unsigned len;
      case (m)
         2: len = leap_year(y) ? 29 : 28;
         4, 6, 9, 11: len = 30;
         default: len = 31;
      endcase
      return len;
   endfunction

   // Running day number of a real date. Shifting the year by one 400-year
   // cycle keeps year 0 and its January and February positive, and the
   // March-based month index puts the leap day at the end of the count year.
   function automatic int unsigned day_number(input int unsigned y,
                                              input int unsigned m,
                                              input int unsigned d);
      int unsigned cy;
      int unsigned cycle;
      int unsigned in_cycle;
      int unsigned mar_month;
      int unsigned in_year;
      cy = y + 400;
      if (m <= 2) begin
         cy = cy - 1;
      end
      cycle     = cy / 400;
      in_cycle  = cy % 400;
      mar_month = (m + 9) % 12;
      in_year   = (153 * mar_month + 2) / 5 + d - 1;
      return cycle * 146097 + in_cycle * 365 + in_cycle / 4 - in_cycle / 100 + in_year;
   endfunction

   // Expected answer for one start date against the current deadline.
   function automatic rsp_word_type count_days_to_deadline(input req_word_type w);
      rsp_word_type ans;
      int unsigned  sy;
      int unsigned  sm;
      int unsigned  sd;
      int unsigned  ey;
      int unsigned  em;
      int unsigned  ed;
      int unsigned  from_day;
      int unsigned  to_day;
      int unsigned  span;
      bit           bad;
      sy = w.start_year;
      sm = w.start_month;
      sd = w.start_day;
      ey = dl_year;
      em = dl_month;
      ed = dl_day;
      span = 0;
      bad = (sm < 1) || (sm > 12) || (sd < 1);
      if (!bad) begin
         bad = sd > days_in_month(sy, sm);
      end
      if (!bad) begin
         // An impossible deadline moves forward to the first real date that
         // does not come before it.
         if (em == 0) begin
            em = 1;
            ed = 1;
         end else if (em > 12) begin
            ey = ey + 1;
            em = 1;
            ed = 1;
         end else if (ed == 0) begin
            ed = 1;
         end else if (ed > days_in_month(ey, em)) begin
            ed = 1;
            if (em == 12) begin
               ey = ey + 1;
               em = 1;
            end else begin
               em = em + 1;
            end
         end
         from_day = day_number(sy, sm, sd);
         to_day   = day_number(ey, em, ed);
         if (from_day < to_day) begin
            span = to_day - from_day;
            if (span > DAYS_CEILING) begin
               span = DAYS_CEILING;
            end
         end
      end
      ans.days_left    = span[DAYS_W-1:0];
      ans.date_invalid = bad;
      return ans;
   endfunction

   function automatic req_word_type make_date(input int unsigned y,
                                              input int unsigned m,
                                              input int unsigned d);
      req_word_type w;
      w.start_year  = y[YEAR_W-1:0];
      w.start_month = m[MONTH_W-1:0];
      w.start_day   = d[DAY_W-1:0];
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Driving the req channel and the deadline registers.
   // ---------------------------------------------------------------------

   // Offers one start date and returns once the block has taken it. The gap
   // before this word was drawn when the previous word went in; valid was
   // already lowered at that time if the gap is not zero.
   task automatic send_date(input req_word_type w);
      if (req_gap > 1) begin
         repeat (req_gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      days_due.push_back(count_days_to_deadline(w));
      req_gap = req_idle ? $urandom_range(0, 19) : 0;
      if (req_gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stops offering words, waits until every answer has come back and lets the
   // block drain, so that it is idle afterwards.
   task automatic wait_for_results();
      if (req_valid) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      while (days_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all three deadline registers, one per cycle. Only called while
   // the block is idle.
   task automatic write_deadline(input int unsigned y,
                                 input int unsigned m,
                                 input int unsigned d);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_DEADLINE_YEAR;
      csr_wr_data <= y[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_index   <= CSR_DEADLINE_MONTH;
      csr_wr_data <= CSR_DATA_W'(m[MONTH_W-1:0]);
      @(negedge clock);
      csr_index   <= CSR_DEADLINE_DAY;
      csr_wr_data <= CSR_DATA_W'(d[DAY_W-1:0]);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      dl_year  = y % (YEAR_TOP + 1);
      dl_month = m % 16;
      dl_day   = d % 32;
   endtask

   // ---------------------------------------------------------------------
   // The rsp side: a receiver that stalls at random and a checker.
   // ---------------------------------------------------------------------

   initial begin : receiver
      int unsigned gap;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         gap = rsp_idle ? $urandom_range(0, 19) : 0;
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Every accepted answer is matched against the oldest one owed.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (days_due.size() == 0) begin
            $error("unexpected rsp word: days_left %0d date_invalid %0b",
                   rsp_data.days_left, rsp_data.date_invalid);
            errors++;
         end else begin
            want = days_due.pop_front();
            if (rsp_data.days_left !== want.days_left) begin
               $error("days_left: expected %0d, actual %0d",
                      want.days_left, rsp_data.days_left);
               errors++;
            end
            if (rsp_data.date_invalid !== want.date_invalid) begin
               $error("date_invalid: expected %0b, actual %0b",
                      want.date_invalid, rsp_data.date_invalid);
               errors++;
            end
         end
      end
   end

   // The watchdog restarts whenever a word moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Start dates against the reset deadline of December 5, 2022: the
   // deadline itself, the days around it, leap days under each leap rule,
   // year zero, impossible months and days, and the ends of the year field.
   task automatic test_reset_deadline();
      send_date(make_date(2022, 12, 5));
      send_date(make_date(2022, 12, 4));
      send_date(make_date(2022, 12, 6));
      send_date(make_date(2022, 1, 1));
      send_date(make_date(2021, 12, 31));
      send_date(make_date(2020, 2, 29));
      send_date(make_date(2021, 2, 29));
      send_date(make_date(1900, 2, 29));
      send_date(make_date(2000, 2, 29));
      send_date(make_date(0, 2, 29));
      send_date(make_date(2022, 0, 10));
      send_date(make_date(2022, 13, 1));
      send_date(make_date(2022, 15, 31));
      send_date(make_date(2022, 6, 0));
      send_date(make_date(2022, 4, 31));
      send_date(make_date(2022, 12, 31));
      send_date(make_date(1, 1, 1));
      send_date(make_date(YEAR_TOP, 12, 31));
      wait_for_results();
   endtask

   // Deadlines at the ends of the range and impossible deadlines, each of
   // which must be read as the next real date. The widest span saturates.
   task automatic test_deadline_extremes();
      write_deadline(1, 1, 1);
      send_date(make_date(0, 1, 1));
      send_date(make_date(0, 12, 31));
      send_date(make_date(1, 1, 1));
      wait_for_results();
      write_deadline(9999, 12, 31);
      send_date(make_date(1, 1, 1));
      send_date(make_date(9999, 12, 30));
      wait_for_results();
      // Month 15 is past December, so this is January 1 after the top year.
      write_deadline(YEAR_TOP, 15, 31);
      send_date(make_date(0, 1, 1));
      send_date(make_date(YEAR_TOP, 12, 31));
      wait_for_results();
      write_deadline(2023, 0, 0);
      send_date(make_date(2022, 12, 31));
      wait_for_results();
      write_deadline(2023, 2, 29);
      send_date(make_date(2023, 2, 28));
      wait_for_results();
      write_deadline(2024, 2, 0);
      send_date(make_date(2024, 1, 31));
      wait_for_results();
      write_deadline(2021, 11, 31);
      send_date(make_date(2021, 11, 30));
      send_date(make_date(2021, 12, 1));
      wait_for_results();
   endtask

   // Draws one start date. Most are real dates a few years around the
   // deadline so that the walker runs through its month and year steps; the
   // rest hit the deadline day, carry impossible fields or are fully random.
   function automatic req_word_type random_start();
      int          y;
      int unsigned m;
      int unsigned d;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      y = int'(dl_year) + int'($urandom_range(0, 8)) - 6;
      if (y < 0) begin
         y = 0;
      end else if (y > int'(YEAR_TOP)) begin
         y = YEAR_TOP;
      end
      if (pick < 70) begin
         m = $urandom_range(1, 12);
         d = $urandom_range(1, days_in_month(y, m));
      end else if (pick < 80) begin
         // On or right around the deadline day.
         y = dl_year;
         m = (dl_month >= 1 && dl_month <= 12) ? dl_month : $urandom_range(1, 12);
         d = dl_day + $urandom_range(0, 2);
         d = (d == 0) ? 0 : d - 1;
      end else if (pick < 90) begin
         m = $urandom_range(0, 15);
         d = $urandom_range(0, 31);
      end else begin
         y = $urandom_range(0, YEAR_TOP);
         m = $urandom_range(0, 15);
         d = $urandom_range(0, 31);
      end
      return make_date(y, m, d);
   endfunction

   // Phases of random start dates, each under a fresh deadline and a fresh
   // choice of idling on the two sides.
   task automatic test_random_dates();
      int unsigned y;
      int unsigned m;
      int unsigned d;
      for (int phase = 0; phase < 18; phase++) begin
         case ($urandom_range(0, 5))
            0: y = 1;
            1: y = 9999;
            2: y = $urandom_range(0, YEAR_TOP);
            default: y = $urandom_range(1900, 2100);
         endcase
         m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
         d = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 28);
         write_deadline(y, m, d);
         req_idle = ($urandom_range(0, 3) != 0);
         rsp_idle = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < 30; k++) begin
            send_date(random_start());
         end
         wait_for_results();
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering words at full rate, so the block fills and stalls req_ready.
   task automatic test_rsp_backpressure();
      write_deadline(2030, 6, 15);
      req_idle = 1'b0;
      hold_rsp = 1'b1;
      for (int k = 0; k < 12; k++) begin
         send_date(random_start());
      end
      wait_for_results();
      req_idle = 1'b1;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (3) @(negedge clock);
      test_reset_deadline();
      test_deadline_extremes();
      test_rsp_backpressure();
      test_random_dates();
      wait_for_results();
      if (errors == 0 && days_due.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

/* sim.f */
src/dud_pkg.sv
src/dud_ctrl.sv
src/dud_datapath.sv
src/days_until_date_counter_core.sv
dv/testbench.sv
